@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`else

`define CHK_SAME(lbl, ante, cons)
`define CHK_NEXT(lbl, ante, cons)

`endif

`endif

@@ hw/rtl/tmvb_pkg.sv @@
// ----------------------------------------------------------------------------
// tmvb_pkg
// Shared widths, register codes and types of the tiled matrix-vector unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmvb_pkg;

    // Beat field widths.
    localparam int OPND_W    = 16;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int ACC_W     = 48;
    localparam int ROW_NUM_W = 10;
    localparam int BIAS_SHIFT = 15;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int TROWS_CFG_W = 7;

    // Default limits and register reset values.
    localparam int MAX_COLS_DEF      = 1024;
    localparam int MAX_ROWS_DEF      = 1024;
    localparam int MAX_TILE_ROWS_DEF = 64;
    localparam int IN_LENGTH_RST     = 400;
    localparam int OUT_LENGTH_RST    = 300;
    localparam int ROWS_PER_TILE_RST = 8;
    localparam int COLS_PER_TILE_RST = 32;

    // Slot field wide enough for the largest allowed tile height.
    localparam int SLOT_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_LENGTH     = 2'd0,
        REG_OUT_LENGTH    = 2'd1,
        REG_ROWS_PER_TILE = 2'd2,
        REG_COLS_PER_TILE = 2'd3
    } t_cfg_reg;

    // Where the next beat falls in the walk.
    typedef struct packed {
        logic [SLOT_W-1:0]    slot;
        logic [ROW_NUM_W-1:0] row;
        logic                 first_col;
        logic                 emit;
        logic                 last_row;
    } t_item_ctrl;

    // Limit a register value to the range 1..hi.
    function automatic int clamp_cfg(input int v, input int hi);
        int r;
        r = v;
        if (v < 1) begin
            r = 1;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/tmvb_in_if.sv @@
// ----------------------------------------------------------------------------
// tmvb_in_if
// Input channel: one weight with its vector element and row bias per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tmvb_in_if;
    import tmvb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [OPND_W-1:0] weight;
    logic signed [OPND_W-1:0] vector_value;
    logic signed [OPND_W-1:0] row_bias;

    modport source (output valid, output weight, output vector_value, output row_bias,
                    input ready);
    modport sink   (input valid, input weight, input vector_value, input row_bias,
                    output ready);
endinterface

@@ hw/rtl/tmvb_out_if.sv @@
// ----------------------------------------------------------------------------
// tmvb_out_if
// Output channel: one finished row sum per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tmvb_out_if;
    import tmvb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [ROW_NUM_W-1:0]     row_number;
    logic signed [ACC_W-1:0]  row_sum;
    logic                     vector_done;

    modport source (output valid, output row_number, output row_sum, output vector_done,
                    input ready);
    modport sink   (input valid, input row_number, input row_sum, input vector_done,
                    output ready);
endinterface

@@ hw/rtl/tmvb_walker.sv @@
// ----------------------------------------------------------------------------
// tmvb_walker
// Configuration registers and the packed tile-order position counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmvb_walker #(
    parameter int MAX_COLS      = tmvb_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS      = tmvb_pkg::MAX_ROWS_DEF,
    parameter int MAX_TILE_ROWS = tmvb_pkg::MAX_TILE_ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  tmvb_pkg::t_cfg_reg                i_cfg_index,
    input  logic [tmvb_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_advance,
    output tmvb_pkg::t_item_ctrl              o_ctrl
);
    import tmvb_pkg::*;

    localparam int ColW  = $clog2(MAX_COLS + 1);
    localparam int RowW  = $clog2(MAX_ROWS + 1);
    localparam int TrW   = $clog2(MAX_TILE_ROWS + 1);
    localparam int SlotW = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1;
    localparam int MaxW  = (RowW > ColW) ? ((RowW > TrW) ? RowW : TrW)
                                         : ((ColW > TrW) ? ColW : TrW);
    localparam int AW    = MaxW + 1;

    // Clamped register values.
    logic [ColW-1:0]  r_n_cols;
    logic [RowW-1:0]  r_n_rows;
    logic [TrW-1:0]   r_t_rows;
    logic [ColW-1:0]  r_t_cols;

    // Walk position.
    logic [RowW-1:0]  r_tfr, n_tfr;
    logic [ColW-1:0]  r_tfc, n_tfc;
    logic [SlotW-1:0] r_rit, n_rit;
    logic [ColW-1:0]  r_cc,  n_cc;

    logic [AW-1:0] w_row, w_cs, w_col_end, w_next_tfr;
    logic          w_row_last, w_rit_last, w_tile_last, w_rt_last, w_col_last;

    always_comb begin
        w_row       = AW'(r_tfr) + AW'(r_rit);
        w_row_last  = (w_row + AW'(1)) >= AW'(r_n_rows);
        w_rit_last  = (AW'(r_rit) + AW'(1)) >= AW'(r_t_rows);
        w_tile_last = w_row_last || w_rit_last;
        w_cs        = AW'(r_tfc) + AW'(r_t_cols);
        w_rt_last   = w_cs >= AW'(r_n_cols);
        w_col_end   = w_rt_last ? AW'(r_n_cols) : w_cs;
        w_col_last  = (AW'(r_cc) + AW'(1)) >= w_col_end;
        w_next_tfr  = AW'(r_tfr) + AW'(r_t_rows);
    end

    always_comb begin
        o_ctrl.slot      = SLOT_W'(r_rit);
        o_ctrl.row       = w_row[ROW_NUM_W-1:0];
        o_ctrl.first_col = (r_cc == '0);
        o_ctrl.emit      = w_col_last && w_rt_last;
        o_ctrl.last_row  = w_row_last;
    end

    always_comb begin
        n_tfr = r_tfr;
        n_tfc = r_tfc;
        n_rit = r_rit;
        n_cc  = ColW'(AW'(r_cc) + AW'(1));
        if (w_col_last) begin
            n_cc = r_tfc;
            if (!w_tile_last) begin
                n_rit = SlotW'(AW'(r_rit) + AW'(1));
            end else begin
                n_rit = '0;
                if (w_rt_last) begin
                    n_tfc = '0;
                    n_tfr = (w_next_tfr >= AW'(r_n_rows)) ? '0 : RowW'(w_next_tfr);
                    n_cc  = '0;
                end else begin
                    n_tfc = ColW'(w_col_end);
                    n_cc  = ColW'(w_col_end);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_cols <= ColW'(clamp_cfg(IN_LENGTH_RST, MAX_COLS));
            r_n_rows <= RowW'(clamp_cfg(OUT_LENGTH_RST, MAX_ROWS));
            r_t_rows <= TrW'(clamp_cfg(ROWS_PER_TILE_RST, MAX_TILE_ROWS));
            r_t_cols <= ColW'(clamp_cfg(COLS_PER_TILE_RST, MAX_COLS));
            r_tfr    <= '0;
            r_tfc    <= '0;
            r_rit    <= '0;
            r_cc     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IN_LENGTH: begin
                    r_n_cols <= ColW'(clamp_cfg(int'(i_cfg_wdata), MAX_COLS));
                end
                REG_OUT_LENGTH: begin
                    r_n_rows <= RowW'(clamp_cfg(int'(i_cfg_wdata), MAX_ROWS));
                end
                REG_ROWS_PER_TILE: begin
                    r_t_rows <= TrW'(clamp_cfg(int'(i_cfg_wdata[TROWS_CFG_W-1:0]),
                                               MAX_TILE_ROWS));
                end
                REG_COLS_PER_TILE: begin
                    r_t_cols <= ColW'(clamp_cfg(int'(i_cfg_wdata), MAX_COLS));
                end
                default: begin
                end
            endcase
            // Any register write restarts the walk at row 0, column 0.
            r_tfr <= '0;
            r_tfc <= '0;
            r_rit <= '0;
            r_cc  <= '0;
        end else if (i_advance) begin
            r_tfr <= n_tfr;
            r_tfc <= n_tfc;
            r_rit <= n_rit;
            r_cc  <= n_cc;
        end
    end

endmodule

@@ hw/rtl/tiled_matvec_bias_packed_stream_unit.sv @@
// A row's last-column beat passes the multiply-stage register, then the output register, which offers the result beat.
// Throughput: one weight beat per cycle, sustained; the input stalls only when the
// multiply stage holds a row-finishing beat and the output register is still held.
// Reset (synchronous, active low) restores the register defaults and restarts the walk.
// The accumulator memory is not cleared; a row seeds its slot on its first column.
// ----------------------------------------------------------------------------
// tiled_matvec_bias_packed_stream_unit
// Dense layer y = W*x + b over a weight stream in packed row-tile order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tiled_matvec_bias_packed_stream_unit #(
    parameter int MAX_COLS      = tmvb_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS      = tmvb_pkg::MAX_ROWS_DEF,
    parameter int MAX_TILE_ROWS = tmvb_pkg::MAX_TILE_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  tmvb_pkg::t_cfg_reg              i_cfg_index,
    input  logic [tmvb_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    tmvb_in_if.sink                         i_in,
    tmvb_out_if.source                      o_out
);
    import tmvb_pkg::*;

    localparam int SlotW = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1;

    // The design is a two-register pipeline. At the accept edge the walker's
    // view of the beat (tile slot, row, first/last column) is captured with
    // the registered product and the slot's parked partial sum read from the
    // accumulator memory. Then the accumulate step adds the product onto the
    // right base; as the stage advances the sum goes to the running accumulator,
    // back into the memory and, for a finished row, into the output register.

    // Handshake and walker.
    logic       w_accept;
    t_item_ctrl w_ctrl;

    // Multiply stage.
    logic                      r_p1_valid;
    t_item_ctrl                r_p1_ctrl;
    logic signed [PROD_W-1:0]  r_p1_prod;
    logic signed [OPND_W-1:0]  r_p1_bias;
    logic signed [ACC_W-1:0]   r_p1_rdata;
    logic                      w_p1_adv;
    logic                      w_p1_go;
    logic signed [PROD_W-1:0]  w_prod;

    // Accumulate stage.
    logic signed [ACC_W-1:0]   r_acc_mem [MAX_TILE_ROWS];
    logic signed [ACC_W-1:0]   r_acc;
    logic [SlotW-1:0]          r_acc_slot;
    logic [SlotW-1:0]          w_p1_slot;
    logic signed [ACC_W-1:0]   w_seed;
    logic signed [ACC_W-1:0]   w_base;
    logic signed [ACC_W-1:0]   w_sum;

    // Output register.
    logic                      r_out_valid;
    logic [ROW_NUM_W-1:0]      r_out_row;
    logic signed [ACC_W-1:0]   r_out_sum;
    logic                      r_out_done;

    // The multiply stage moves on unless it holds a finished row that the
    // output register cannot take yet.
    assign w_p1_adv   = !r_p1_ctrl.emit || !r_out_valid || o_out.ready;
    assign w_p1_go    = r_p1_valid && w_p1_adv;
    assign i_in.ready = !r_p1_valid || w_p1_adv;
    assign w_accept   = i_in.valid && i_in.ready;

    tmvb_walker #(
        .MAX_COLS      (MAX_COLS),
        .MAX_ROWS      (MAX_ROWS),
        .MAX_TILE_ROWS (MAX_TILE_ROWS)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_advance   (w_accept),
        .o_ctrl      (w_ctrl)
    );

    assign w_prod = i_in.weight * i_in.vector_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (w_accept || w_p1_go) begin
            r_p1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p1_ctrl <= w_ctrl;
            r_p1_prod <= w_prod;
            r_p1_bias <= i_in.row_bias;
        end
    end

    // Registered read of the slot's parked partial sum, taken at the accept edge.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p1_rdata <= r_acc_mem[w_ctrl.slot[SlotW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p1_go) begin
            r_acc_mem[w_p1_slot] <= w_sum;
        end
    end

    // On column 0 the bias, scaled to Q17.30, seeds the row. Otherwise the
    // base is the running accumulator when the previous beat worked on the
    // same slot (it is newer than the memory read, which may have been taken
    // at the very edge that wrote that slot); else the parked value.
    assign w_p1_slot = r_p1_ctrl.slot[SlotW-1:0];
    assign w_seed    = {{(ACC_W - OPND_W - BIAS_SHIFT){r_p1_bias[OPND_W-1]}},
                        r_p1_bias, {BIAS_SHIFT{1'b0}}};

    always_comb begin
        if (r_p1_ctrl.first_col) begin
            w_base = w_seed;
        end else if (r_acc_slot == w_p1_slot) begin
            w_base = r_acc;
        end else begin
            w_base = r_p1_rdata;
        end
        w_sum = w_base + {{(ACC_W - PROD_W){r_p1_prod[PROD_W-1]}}, r_p1_prod};
    end

    always_ff @(posedge i_clk) begin
        if (w_p1_go) begin
            r_acc      <= w_sum;
            r_acc_slot <= w_p1_slot;
        end
    end

    // Output register: loads a finished row, holds it until the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_p1_go && r_p1_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p1_go && r_p1_ctrl.emit) begin
            r_out_row  <= r_p1_ctrl.row;
            r_out_sum  <= w_sum;
            r_out_done <= r_p1_ctrl.last_row;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.row_number  = r_out_row;
    assign o_out.row_sum     = r_out_sum;
    assign o_out.vector_done = r_out_done;

    // The input is held off only by a finished row waiting behind a held output.
    `CHK_SAME(a_ready_only_on_stall, !i_in.ready,
              r_p1_valid && r_p1_ctrl.emit && r_out_valid && !o_out.ready)
    // A finished row leaving the multiply stage always lands in the output register.
    `CHK_NEXT(a_emit_reaches_output, w_p1_go && r_p1_ctrl.emit, r_out_valid)
    // After the last row of the vector the walk is back at row 0, column 0.
    `CHK_NEXT(a_wrap_after_vector, w_accept && w_ctrl.emit && w_ctrl.last_row,
              w_ctrl.first_col && (w_ctrl.slot == '0) && (w_ctrl.row == '0))

endmodule
